>>> design/dpp_pkg.sv
// Shared types and constants for the depth pixel to point unprojection block.
// Used by every module of the block; depends on nothing.
package dpp_pkg;

  localparam int MAX_SIDE = 128;
  localparam int POS_W = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE) + 1;
  localparam int CODE_W = 8;
  localparam int CFG_W = 26;
  localparam int FRAC_W = 18;
  localparam int SQ_W = 2 * CODE_W;
  localparam int DEN_PROD_W = 41;
  localparam int PROD_W = SQ_W + CFG_W;
  localparam int NUM_W = 60;
  localparam int DEN_W = 42;
  localparam int QUO_W = 25;
  localparam int XY_W = 24;
  localparam int Z_W = 18;
  localparam int QUEUE_DEPTH = 2;

  localparam int Z_NUM_W = 32;
  localparam int Z_RECIP_W = 18;
  localparam int Z_PROD_W = SQ_W + Z_RECIP_W;

  localparam logic [14:0] DEPTH_DEN = 15'd26010;
  localparam logic [13:0] DEPTH_HALF = 14'd13005;
  localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(8388607);
  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(8388608);
  localparam logic [Z_W-1:0] Z_MAX = Z_W'(163840);

  // floor(2^32 / 26010), so that (sq * Z_RECIP) >> 16 never overshoots the quotient.
  localparam logic [Z_RECIP_W-1:0] Z_RECIP = Z_RECIP_W'(165127);
  localparam logic [Z_NUM_W-1:0] Z_DEN_1X = Z_NUM_W'(26010);
  localparam logic [Z_NUM_W-1:0] Z_DEN_2X = Z_NUM_W'(52020);

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  typedef struct packed {
    logic [CFG_W-1:0] focal_x;
    logic [CFG_W-1:0] focal_y;
    logic [CFG_W-1:0] center_x;
    logic [CFG_W-1:0] center_y;
    logic [SIDE_W-1:0] frame_width;
    logic [SIDE_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic frame_end;
  } pixel_t;

endpackage

>>> design/dpp_front.sv
// Front end: accepts pixel requests, tracks column and row, flags frame end.
// Depends on dpp_pkg.
module dpp_front import dpp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic push,
  input  logic [CODE_W-1:0] depth_code,
  input  logic frame_start,
  input  logic q_full,
  output logic q_push,
  output pixel_t q_entry
);

  logic [POS_W-1:0] column_count;
  logic [POS_W-1:0] row_count;
  logic [POS_W-1:0] column_count_next;
  logic [POS_W-1:0] row_count_next;
  logic [POS_W-1:0] col_cur;
  logic [POS_W-1:0] row_cur;
  logic [SIDE_W-1:0] side_w;
  logic [SIDE_W-1:0] side_h;
  logic [SIDE_W-1:0] col_inc;
  logic [SIDE_W-1:0] row_inc;

  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] v);
    if (v == '0 || v > SIDE_W'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end
    return v;
  endfunction

  always_comb begin
    side_w = side_of(cfg.frame_width);
    side_h = side_of(cfg.frame_height);
    col_cur = frame_start ? '0 : column_count;
    row_cur = frame_start ? '0 : row_count;
    col_inc = SIDE_W'(col_cur) + SIDE_W'(1);
    row_inc = SIDE_W'(row_cur) + SIDE_W'(1);
    if (col_inc >= side_w) begin
      column_count_next = '0;
      row_count_next = (row_inc >= side_h) ? '0 : row_inc[POS_W-1:0];
    end else begin
      column_count_next = col_inc[POS_W-1:0];
      row_count_next = row_cur;
    end
    q_push = push && !q_full;
    q_entry.code = depth_code;
    q_entry.col = col_cur;
    q_entry.row = row_cur;
    q_entry.frame_end = (SIDE_W'(col_cur) == side_w - SIDE_W'(1)) &&
                        (SIDE_W'(row_cur) == side_h - SIDE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
    end else if (q_push) begin
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

>>> design/dpp_queue.sv
// Short queue that decouples the front end from the arithmetic back end.
// Depends on dpp_pkg.
module dpp_queue import dpp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  pixel_t wr_data,
  input  logic rd_en,
  output pixel_t rd_data,
  output logic full,
  output logic empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pixel_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> design/dpp_divider.sv
// Restoring divider giving one quotient bit per cycle, with an overflow flag.
// Depends on dpp_pkg.
module dpp_divider import dpp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic done,
  output logic overflow,
  output logic [QUO_W-1:0] quotient
);

  localparam int SHIFT_W = DEN_W + QUO_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [NUM_W-1:0] rem;
  logic [SHIFT_W-1:0] divisor;
  logic [CNT_W-1:0] count;
  logic active;
  logic fits;

  assign fits = SHIFT_W'(rem) >= divisor;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= numer;
      divisor <= SHIFT_W'(denom) << (QUO_W - 1);
      overflow <= SHIFT_W'(numer) >= {denom, {QUO_W{1'b0}}};
      quotient <= '0;
    end else if (active) begin
      if (fits) begin
        rem <= rem - divisor[NUM_W-1:0];
      end
      quotient <= {quotient[QUO_W-2:0], fits};
      divisor <= divisor >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count <= CNT_W'(QUO_W);
      end else if (active) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/dpp_back.sv
// Back end: squares the depth code, forms the numerators and runs two dividers for x and y;
// z comes from a reciprocal multiplication with a small remainder correction.
// Depends on dpp_pkg and dpp_divider.
module dpp_back import dpp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_empty,
  input  pixel_t q_entry,
  output logic q_pop,
  input  logic pop,
  output logic empty,
  output logic signed [XY_W-1:0] point_x,
  output logic signed [XY_W-1:0] point_y,
  output logic [Z_W-1:0] point_z,
  output logic frame_end
);

  localparam int SCALE_SH = 17;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SQUARE  = 7'b0000010,
    S_PRODUCT = 7'b0000100,
    S_SUM     = 7'b0001000,
    S_LAUNCH  = 7'b0010000,
    S_DIVIDE  = 7'b0100000,
    S_HOLD    = 7'b1000000
  } state_t;

  state_t state;
  pixel_t item;
  logic out_valid;
  logic [SQ_W-1:0] sq;
  logic [CFG_W-1:0] mag_x;
  logic [CFG_W-1:0] mag_y;
  logic neg_x;
  logic neg_y;
  logic [DEN_PROD_W-1:0] den_x;
  logic [DEN_PROD_W-1:0] den_y;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic [NUM_W-1:0] numer_x;
  logic [NUM_W-1:0] numer_y;
  logic [Z_NUM_W-1:0] numer_z;
  logic [DEN_W-1:0] denom_x;
  logic [DEN_W-1:0] denom_y;
  logic [Z_PROD_W-1:0] z_prod;
  logic [Z_W-1:0] z_est;
  logic [Z_NUM_W-1:0] z_back;
  logic [Z_NUM_W-1:0] z_rem;
  logic [XY_W-1:0] res_x;
  logic [XY_W-1:0] res_y;
  logic [Z_W-1:0] res_z;
  logic div_start;
  logic done_x;
  logic done_y;
  logic ovf_x;
  logic ovf_y;
  logic [QUO_W-1:0] quo_x;
  logic [QUO_W-1:0] quo_y;

  function automatic logic [CFG_W-1:0] offset_mag(input logic [POS_W-1:0] pos,
                                                  input logic [CFG_W-1:0] ctr);
    logic [CFG_W-1:0] p;
    p = CFG_W'({pos, {FRAC_W{1'b0}}});
    return (p < ctr) ? ctr - p : p - ctr;
  endfunction

  function automatic logic offset_neg(input logic [POS_W-1:0] pos,
                                      input logic [CFG_W-1:0] ctr);
    return CFG_W'({pos, {FRAC_W{1'b0}}}) < ctr;
  endfunction

  function automatic logic [CFG_W-1:0] focal_of(input logic [CFG_W-1:0] f);
    return (f == '0) ? CFG_W'(1) : f;
  endfunction

  function automatic logic [XY_W-1:0] signed_result(input logic [QUO_W-1:0] q,
                                                    input logic ovf,
                                                    input logic neg);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mag;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    mag = (ovf || q > lim) ? lim : q;
    return neg ? XY_W'(QUO_W'(0) - mag) : XY_W'(mag);
  endfunction

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign div_start = (state == S_LAUNCH);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          item <= q_entry;
        end
      end
      S_SQUARE: begin
        sq <= item.code * item.code;
        den_x <= DEPTH_DEN * focal_of(cfg.focal_x);
        den_y <= DEPTH_DEN * focal_of(cfg.focal_y);
        mag_x <= offset_mag(item.col, cfg.center_x);
        mag_y <= offset_mag(item.row, cfg.center_y);
        neg_x <= offset_neg(item.col, cfg.center_x);
        neg_y <= offset_neg(item.row, cfg.center_y);
      end
      S_PRODUCT: begin
        prod_x <= sq * mag_x;
        prod_y <= sq * mag_y;
        z_prod <= Z_PROD_W'(sq) * Z_PROD_W'(Z_RECIP);
      end
      S_SUM: begin
        numer_x <= NUM_W'({prod_x, {SCALE_SH{1'b0}}}) + NUM_W'(den_x);
        numer_y <= NUM_W'({prod_y, {SCALE_SH{1'b0}}}) + NUM_W'(den_y);
        numer_z <= Z_NUM_W'({sq, {(SCALE_SH - 1){1'b0}}}) + Z_NUM_W'(DEPTH_HALF);
        denom_x <= {den_x, 1'b0};
        denom_y <= {den_y, 1'b0};
        z_est <= z_prod[Z_PROD_W-1:Z_PROD_W-Z_W];
      end
      S_LAUNCH: begin
        z_back <= Z_NUM_W'(z_est) * Z_DEN_1X;
      end
      S_DIVIDE: begin
        z_rem <= numer_z - z_back;
        if (done_x && done_y) begin
          res_x <= signed_result(quo_x, ovf_x, neg_x);
          res_y <= signed_result(quo_y, ovf_y, neg_y);
          res_z <= z_est + Z_W'(z_rem >= Z_DEN_1X) + Z_W'(z_rem >= Z_DEN_2X);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == S_HOLD) && (!out_valid || pop)) begin
      point_x <= res_x;
      point_y <= res_y;
      point_z <= res_z;
      frame_end <= item.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_HOLD) && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          state <= S_PRODUCT;
        end
        S_PRODUCT: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_LAUNCH;
        end
        S_LAUNCH: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (done_x && done_y) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid || pop) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dpp_divider u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .numer(numer_x), .denom(denom_x),
    .done(done_x), .overflow(ovf_x), .quotient(quo_x)
  );

  dpp_divider u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .numer(numer_y), .denom(denom_y),
    .done(done_y), .overflow(ovf_y), .quotient(quo_y)
  );

endmodule

>>> design/depth_pixel_to_point.sv
// Top level of the depth pixel to point unprojection block.
// Depends on dpp_pkg, dpp_front, dpp_queue and dpp_back.
//
// Pixels are pushed in raster order and each gives one point, in order, on
// the result side. The front end takes a pixel request in the cycle it is
// pushed and places it in a two-entry queue; the back end then works on one
// pixel at a time while the result side keeps up, paced mostly by the two
// restoring dividers for x and y that produce one quotient bit per cycle;
// z is formed alongside them. A finished point waits in the output register
// while the back end moves on to the next pixel. Configuration is to be
// written through cfg_write, cfg_index and cfg_data only while the block
// is idle; the block itself does not enforce this.
module depth_pixel_to_point import dpp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic push,
  output logic full,
  input  logic [CODE_W-1:0] depth_code,
  input  logic frame_start,
  output logic empty,
  input  logic pop,
  output logic signed [XY_W-1:0] point_x,
  output logic signed [XY_W-1:0] point_y,
  output logic [Z_W-1:0] point_z,
  output logic frame_end
);

  cfg_t cfg;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  pixel_t push_entry;
  pixel_t pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x <= CFG_W'(19660800);
      cfg.focal_y <= CFG_W'(19660800);
      cfg.center_x <= CFG_W'(13107200);
      cfg.center_y <= CFG_W'(13107200);
      cfg.frame_width <= SIDE_W'(100);
      cfg.frame_height <= SIDE_W'(100);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FOCAL_X: cfg.focal_x <= cfg_data;
        REG_FOCAL_Y: cfg.focal_y <= cfg_data;
        REG_CENTER_X: cfg.center_x <= cfg_data;
        REG_CENTER_Y: cfg.center_y <= cfg_data;
        REG_FRAME_WIDTH: cfg.frame_width <= cfg_data[SIDE_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[SIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign full = q_full;

  dpp_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .push(push), .depth_code(depth_code),
    .frame_start(frame_start), .q_full(q_full), .q_push(q_push),
    .q_entry(push_entry)
  );

  dpp_queue u_queue (
    .clk(clk), .rst(rst), .wr_en(q_push), .wr_data(push_entry), .rd_en(q_pop),
    .rd_data(pop_entry), .full(q_full), .empty(q_empty)
  );

  dpp_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_entry(pop_entry),
    .q_pop(q_pop), .pop(pop), .empty(empty), .point_x(point_x),
    .point_y(point_y), .point_z(point_z), .frame_end(frame_end)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> point_z <= Z_MAX)
    else $error("depth result beyond its range");

endmodule

>>> tb/tb_depth_pixel_to_point.sv
// Testbench for depth_pixel_to_point: pushes raster pixel streams under several
// intrinsics and frame sizes and checks every popped point against a predictor.
// Depends on dpp_pkg and the depth_pixel_to_point RTL.
`timescale 1ns / 100ps

module tb_depth_pixel_to_point;
  import dpp_pkg::*;

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [Z_W-1:0] z;
    logic last;
  } point_t;

  typedef struct {
    logic [CFG_W-1:0] focal_x;
    logic [CFG_W-1:0] focal_y;
    logic [CFG_W-1:0] center_x;
    logic [CFG_W-1:0] center_y;
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
  } setup_t;

  class point_scoreboard;
    logic [CFG_W-1:0] focal_x, focal_y, center_x, center_y;
    logic [7:0] frame_width, frame_height;
    int unsigned column_pos, row_pos;
    point_t pending_points[$];
    int unsigned fail_count;

    function new();
      focal_x = 26'd19660800;
      focal_y = 26'd19660800;
      center_x = 26'd13107200;
      center_y = 26'd13107200;
      frame_width = 8'd100;
      frame_height = 8'd100;
      column_pos = 0;
      row_pos = 0;
      fail_count = 0;
    endfunction

    function void set_register(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      case (idx)
        REG_FOCAL_X: focal_x = value;
        REG_FOCAL_Y: focal_y = value;
        REG_CENTER_X: center_x = value;
        REG_CENTER_Y: center_y = value;
        REG_FRAME_WIDTH: frame_width = value[7:0];
        REG_FRAME_HEIGHT: frame_height = value[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned side_len(input logic [7:0] v);
      return (v == 0 || v > MAX_SIDE) ? MAX_SIDE : v;
    endfunction

    function logic [XY_W-1:0] unproject_axis(input int unsigned code, input int unsigned pos,
                                             input longint unsigned center,
                                             input longint unsigned focal);
      longint unsigned sq, p, mag, num, den, q;
      bit neg;
      sq = code * code;
      p = pos;
      p = p << FRAC_W;
      neg = p < center;
      mag = neg ? center - p : p - center;
      if (focal == 0) focal = 1;
      num = (sq * mag) << 16;
      den = focal * DEPTH_DEN;
      q = (2 * num + den) / (2 * den);
      if (neg) begin
        if (q > NEG_LIMIT) q = NEG_LIMIT;
        return XY_W'(64'd0 - q);
      end
      if (q > POS_LIMIT) q = POS_LIMIT;
      return XY_W'(q);
    endfunction

    function void note_pixel(input logic [CODE_W-1:0] code, input logic start);
      int unsigned w, h, c;
      longint unsigned zq;
      point_t p;
      w = side_len(frame_width);
      h = side_len(frame_height);
      c = code;
      if (start) begin
        column_pos = 0;
        row_pos = 0;
      end
      p.x = unproject_axis(c, column_pos, center_x, focal_x);
      p.y = unproject_axis(c, row_pos, center_y, focal_y);
      zq = c * c;
      zq = ((zq << 16) + DEPTH_HALF) / DEPTH_DEN;
      p.z = Z_W'(zq);
      p.last = (column_pos == w - 1 && row_pos == h - 1);
      pending_points.insert(pending_points.size(), p);
      column_pos++;
      if (column_pos >= w) begin
        column_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void check_point(input point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        $error("point popped with no pixel request pending");
        fail_count++;
        return;
      end
      want = pending_points.pop_front();
      if (got.x !== want.x) begin
        $error("point_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
        fail_count++;
      end
      if (got.y !== want.y) begin
        $error("point_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
        fail_count++;
      end
      if (got.z !== want.z) begin
        $error("point_z: expected %0d, got %0d", want.z, got.z);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("frame_end: expected %0b, got %0b", want.last, got.last);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [CODE_W-1:0] depth_code = '0;
  logic frame_start = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [XY_W-1:0] point_x;
  logic signed [XY_W-1:0] point_y;
  logic [Z_W-1:0] point_z;
  logic frame_end;

  point_scoreboard sb = new();
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_left = 0;
  int unsigned idle_pct[6] = '{0, 88, 0, 13, 0, 88};
  int unsigned stall_pct[6] = '{0, 0, 88, 13, 0, 88};
  logic [CODE_W-1:0] frame_a_codes[15] = '{8'd255, 8'd0, 8'd1, 8'd254, 8'd128, 8'd255, 8'd17,
                                           8'd200, 8'd255, 8'd3, 8'd99, 8'd255, 8'd64, 8'd255,
                                           8'd255};

  depth_pixel_to_point i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .depth_code(depth_code),
    .frame_start(frame_start),
    .empty(empty),
    .pop(pop),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .frame_end(frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_pixel(depth_code, frame_start);
      if (pop && !empty) sb.check_point({point_x, point_y, point_z, frame_end});
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic load_setup(input setup_t s);
    write_reg(REG_FOCAL_X, s.focal_x);
    write_reg(REG_FOCAL_Y, s.focal_y);
    write_reg(REG_CENTER_X, s.center_x);
    write_reg(REG_CENTER_Y, s.center_y);
    write_reg(REG_FRAME_WIDTH, s.frame_width);
    write_reg(REG_FRAME_HEIGHT, s.frame_height);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [CODE_W-1:0] code, input logic start);
    push <= 1'b1;
    depth_code <= code;
    frame_start <= start;
    do @(posedge clk); while (full);
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic send_frames(input int unsigned count);
    int unsigned sent, len;
    bit marked;
    sent = 0;
    while (sent < count) begin
      len = sb.side_len(sb.frame_width) * sb.side_len(sb.frame_height);
      if ($urandom_range(9) == 0) len = $urandom_range(len, 1);
      marked = ($urandom_range(9) != 0);
      for (int unsigned i = 0; i < len && sent < count; i++) begin
        send_pixel(($urandom_range(15) == 0) ? 8'd255 : 8'($urandom_range(255)),
                   (i == 0) ? marked : ($urandom_range(99) == 0));
        sent++;
      end
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    setup_t s;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One small frame with the centre inside it, then a restart part-way through.
    load_setup('{26'd19660800, 26'd19660800, 26'd524288, 26'd393216, 26'd4, 26'd3});
    for (int i = 0; i < 15; i++) send_pixel(frame_a_codes[i], i == 0 || i == 13);
    wait_idle();

    // Zero and unit focal lengths drive both saturation limits.
    load_setup('{26'd0, 26'd1, 26'h3FFFFFF, 26'd0, 26'd1, 26'd255});
    for (int i = 0; i < 6; i++) send_pixel((i == 2) ? 8'd0 : 8'd255, i == 0);
    wait_idle();

    // The frame shrinks under a row counter that is already beyond it.
    load_setup('{26'd655360, 26'd33554432, 26'd262144, 26'd33554432, 26'h302, 26'd3});
    for (int i = 0; i < 8; i++) send_pixel(8'($urandom_range(255)), 1'b0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      s.focal_x = CFG_W'(($urandom_range(3) == 0) ? $urandom_range(26'h3FFFFFF, 1)
                                                  : $urandom_range(150 << 18, 20 << 18));
      s.focal_y = CFG_W'(($urandom_range(3) == 0) ? $urandom_range(26'h3FFFFFF, 1)
                                                  : $urandom_range(150 << 18, 20 << 18));
      s.center_x = CFG_W'($urandom_range(33554432, 0));
      s.center_y = CFG_W'($urandom_range(33554432, 0));
      s.frame_width = CFG_W'(($urandom_range(4) == 0) ? $urandom_range(255, 100)
                                                      : $urandom_range(12, 1));
      s.frame_height = CFG_W'(($urandom_range(4) == 0) ? $urandom_range(255, 100)
                                                       : $urandom_range(12, 1));
      if (ph == 0) begin
        s.focal_x = 26'h3FFFFFF;
        s.focal_y = 26'h3FFFFFF;
        s.center_x = 26'd33554432;
        s.center_y = 26'd0;
        s.frame_width = 26'd128;
        s.frame_height = 26'd1;
      end
      if (ph == 1) begin
        s.frame_width = 26'd0;
        s.frame_height = 26'd2;
      end
      load_setup(s);
      send_idle = idle_pct[ph];
      recv_stall = stall_pct[ph];
      if (ph == 0 || ph == 4) hold_left = 300;
      send_frames(170);
      wait_idle();
    end

    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("run did not complete, %0d points still outstanding", sb.pending_points.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/dpp_pkg.sv
design/dpp_front.sv
design/dpp_queue.sv
design/dpp_divider.sv
design/dpp_back.sv
design/depth_pixel_to_point.sv
tb/tb_depth_pixel_to_point.sv
